// File: hdl/lsdw_pkg.sv
// ----------------------------------------------------------------------------
// lsdw_pkg
// shared types and constants for the lo synthesizer divider writer
// ----------------------------------------------------------------------------
`default_nettype none

package lsdw_pkg;

    localparam int QUEUE_DEPTH = 2;

    // frequency limits in hertz
    localparam logic [32:0] FREQ_MIN_HZ  = 33'd85000000;
    localparam logic [32:0] FREQ_MAX_HZ  = 33'd4200000000;
    localparam logic [32:0] VCO_HALF_HZ  = 33'd2700000000;
    localparam logic [37:0] PRESC_THR_HZ = 38'd3200000000;
    localparam int          LO_DIV_MAX   = 5;

    // freq / 312500 = (freq >> 2) / 78125, done as a multiply by 2^47 / 78125 (rounded up)
    localparam int          FQ_W        = 30;
    localparam int          RECIP_W     = 31;
    localparam logic [30:0] FREQ_RECIP  = 31'd1801439851;
    localparam int          RECIP_SHIFT = 47;
    localparam int          PROD_W      = FQ_W + RECIP_W;
    localparam int          QUOT_W      = 14;

    // device register addresses
    localparam logic [4:0] ADDR_NONE     = 5'd0;
    localparam logic [4:0] ADDR_PLL_CTRL = 5'd9;
    localparam logic [4:0] ADDR_FRAC_HI  = 5'd16;
    localparam logic [4:0] ADDR_N_WORD   = 5'd17;

    typedef enum logic [1:0] {
        BEAT_CTRL,
        BEAT_FRAC,
        BEAT_NWORD
    } beat_t;

    // one classified request as it travels from front to back
    typedef struct packed {
        logic            rejected;
        logic [2:0]      lo_div;
        logic            presc_hi;
        logic [FQ_W-1:0] freq_q;
    } cmd_t;

endpackage

`default_nettype wire

// File: hdl/lsdw_front.sv
// ----------------------------------------------------------------------------
// lsdw_front
// range check, lo divider and prescaler choice for each requested frequency
// ----------------------------------------------------------------------------
`default_nettype none

module lsdw_front
(
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic [32:0]   freq_hz,
    output logic               push_valid,
    input  wire logic          push_ready,
    output lsdw_pkg::cmd_t     push_data
);

    logic [2:0]  lo_div;
    logic [37:0] fvco;

    always_comb
    begin
        lo_div = 3'd0;
        // thresholds fall with k, so counting the hits gives the loop count
        for (int k = 0; k < lsdw_pkg::LO_DIV_MAX; k++)
        begin
            if ((lsdw_pkg::VCO_HALF_HZ >> k) >= freq_hz)
            begin
                lo_div = lo_div + 3'd1;
            end
        end
        fvco = {5'd0, freq_hz} << lo_div;
    end

    always_comb
    begin
        push_data.rejected = (freq_hz < lsdw_pkg::FREQ_MIN_HZ) ||
                             (freq_hz > lsdw_pkg::FREQ_MAX_HZ);
        push_data.lo_div   = lo_div;
        push_data.presc_hi = fvco > lsdw_pkg::PRESC_THR_HZ;
        push_data.freq_q   = freq_hz[31:2];
    end

    assign push_valid = in_valid;
    assign in_ready   = push_ready;

endmodule

`default_nettype wire

// File: hdl/lsdw_queue.sv
// ----------------------------------------------------------------------------
// lsdw_queue
// small first-in first-out queue of classified requests
// ----------------------------------------------------------------------------
`default_nettype none

module lsdw_queue
#(
    parameter int DEPTH = lsdw_pkg::QUEUE_DEPTH
)
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push_valid,
    output logic                push_ready,
    input  wire lsdw_pkg::cmd_t push_data,
    output logic                pop_valid,
    input  wire logic           pop_ready,
    output lsdw_pkg::cmd_t      pop_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    lsdw_pkg::cmd_t   entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = count_reg != CNT_W'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_data   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// File: hdl/lsdw_back.sv
// ----------------------------------------------------------------------------
// lsdw_back
// fractional-n computation and sequencing of the register write transactions
// ----------------------------------------------------------------------------
`default_nettype none

module lsdw_back
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic [15:0]    pll_ctrl_base,
    input  wire logic           pop_valid,
    output logic                pop_ready,
    input  wire lsdw_pkg::cmd_t pop_data,
    output logic                out_valid,
    input  wire logic           out_ready,
    output logic [4:0]          reg_addr,
    output logic [15:0]         reg_data,
    output logic                rejected,
    output logic                last
);

    // multiply stage
    logic                          m_valid_reg, m_valid_next;
    logic                          m_rej_reg;
    logic [2:0]                    m_n_reg;
    logic                          m_phi_reg;
    logic [lsdw_pkg::PROD_W-1:0]   m_prod_reg;

    // emit stage
    logic                          e_valid_reg, e_valid_next;
    lsdw_pkg::beat_t               beat_reg, beat_next;
    logic                          e_rej_reg;
    logic                          e_phi_reg;
    logic [15:0]                   e_frac_reg, e_frac_next;
    logic [15:0]                   e_nword_reg, e_nword_next;

    logic                          e_done, e_free, m_adv, m_free, do_pop;
    logic [lsdw_pkg::QUOT_W-1:0]   quot;
    logic [lsdw_pkg::QUOT_W:0]     round_sum;
    logic [1:0]                    p_val;
    logic [4:0]                    step_shift;
    logic [35:0]                   t_val;

    assign last      = e_rej_reg || (beat_reg == lsdw_pkg::BEAT_NWORD);
    assign out_valid = e_valid_reg;
    assign rejected  = e_rej_reg;
    assign e_done    = e_valid_reg && out_ready && last;
    assign e_free    = !e_valid_reg || e_done;
    assign m_adv     = m_valid_reg && e_free;
    assign m_free    = !m_valid_reg || m_adv;
    assign pop_ready = m_free;
    assign do_pop    = pop_valid && m_free;

    // round(freq / 625000) half up, then placed at the fraction step
    always_comb
    begin
        quot       = m_prod_reg[lsdw_pkg::RECIP_SHIFT +: lsdw_pkg::QUOT_W];
        round_sum  = {1'b0, quot} + 15'd1;
        p_val      = m_phi_reg ? 2'd2 : 2'd1;
        step_shift = (m_phi_reg ? 5'd16 : 5'd17) + {2'b00, m_n_reg};
        t_val      = {22'd0, round_sum[lsdw_pkg::QUOT_W:1]} << step_shift;
        e_frac_next  = t_val[23:8];
        e_nword_next = {4'd0, p_val, m_n_reg, t_val[30:24]};
    end

    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (do_pop)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_adv)
        begin
            m_valid_next = 1'b0;
        end

        e_valid_next = e_valid_reg;
        beat_next    = beat_reg;
        if (m_adv)
        begin
            e_valid_next = 1'b1;
            beat_next    = lsdw_pkg::BEAT_CTRL;
        end
        else if (e_done)
        begin
            e_valid_next = 1'b0;
            beat_next    = lsdw_pkg::BEAT_CTRL;
        end
        else if (e_valid_reg && out_ready)
        begin
            case (beat_reg)
                lsdw_pkg::BEAT_CTRL: beat_next = lsdw_pkg::BEAT_FRAC;
                lsdw_pkg::BEAT_FRAC: beat_next = lsdw_pkg::BEAT_NWORD;
                default:             beat_next = lsdw_pkg::BEAT_CTRL;
            endcase
        end
    end

    always_comb
    begin
        reg_addr = lsdw_pkg::ADDR_NONE;
        reg_data = 16'd0;
        if (!e_rej_reg)
        begin
            case (beat_reg)
                lsdw_pkg::BEAT_CTRL:
                begin
                    reg_addr = lsdw_pkg::ADDR_PLL_CTRL;
                    // charge-pump level is 2 or 3
                    reg_data = {pll_ctrl_base[15:2], 1'b1, e_phi_reg};
                end
                lsdw_pkg::BEAT_FRAC:
                begin
                    reg_addr = lsdw_pkg::ADDR_FRAC_HI;
                    reg_data = e_frac_reg;
                end
                lsdw_pkg::BEAT_NWORD:
                begin
                    reg_addr = lsdw_pkg::ADDR_N_WORD;
                    reg_data = e_nword_reg;
                end
                default:
                begin
                    reg_addr = lsdw_pkg::ADDR_NONE;
                    reg_data = 16'd0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
            beat_reg    <= lsdw_pkg::BEAT_CTRL;
            e_rej_reg   <= 1'b0;
        end
        else
        begin
            m_valid_reg <= m_valid_next;
            e_valid_reg <= e_valid_next;
            beat_reg    <= beat_next;
            if (m_adv)
            begin
                e_rej_reg <= m_rej_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_pop)
        begin
            m_rej_reg  <= pop_data.rejected;
            m_n_reg    <= pop_data.lo_div;
            m_phi_reg  <= pop_data.presc_hi;
            m_prod_reg <= lsdw_pkg::PROD_W'(pop_data.freq_q) *
                          lsdw_pkg::PROD_W'(lsdw_pkg::FREQ_RECIP);
        end
        if (m_adv)
        begin
            e_phi_reg   <= m_phi_reg;
            e_frac_reg  <= e_frac_next;
            e_nword_reg <= e_nword_next;
        end
    end

endmodule

`default_nettype wire

// File: hdl/lo_synth_divider_writer.sv
// ----------------------------------------------------------------------------
// lo_synth_divider_writer
// turns a requested lo frequency into pll control, fraction and n register writes
// ----------------------------------------------------------------------------
// Each accepted frequency yields three write transactions (pll control at 9,
// fraction upper word at 16, n word at 17, last set on the third); a frequency
// outside 85 MHz to 4.2 GHz yields one transaction with rejected and last set
// and zero address and data. A new frequency can be taken every cycle while the
// front queue has room; the sustained rate is set by the three output beats of
// the write sequencer (one for a rejected frequency) and by out_ready. Inputs are
// classified into the queue, then registered in the reciprocal multiplier stage
// and the emit stage. pll_ctrl_base is written over its own always-ready channel;
// the user must write it only while the block is idle; the block does not enforce it.
`default_nettype none

module lo_synth_divider_writer
#(
    parameter int QUEUE_DEPTH = lsdw_pkg::QUEUE_DEPTH
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [15:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [32:0] freq_hz,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [4:0]       reg_addr,
    output logic [15:0]      reg_data,
    output logic             rejected,
    output logic             last
);

    logic [15:0]    pll_ctrl_base_reg;
    logic           push_valid, push_ready;
    lsdw_pkg::cmd_t push_data;
    logic           pop_valid, pop_ready;
    lsdw_pkg::cmd_t pop_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pll_ctrl_base_reg <= 16'd0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            pll_ctrl_base_reg <= cfg_data;
        end
    end

    lsdw_front u_front
    (
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .freq_hz    (freq_hz),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    lsdw_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    lsdw_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .pll_ctrl_base (pll_ctrl_base_reg),
        .pop_valid     (pop_valid),
        .pop_ready     (pop_ready),
        .pop_data      (pop_data),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .reg_addr      (reg_addr),
        .reg_data      (reg_data),
        .rejected      (rejected),
        .last          (last)
    );

endmodule

`default_nettype wire

// File: hdl/lsdw_checker.sv
// ----------------------------------------------------------------------------
// lsdw_props
// port-level checks on the register write transactions
// ----------------------------------------------------------------------------
`default_nettype none

module lsdw_props
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [4:0]  reg_addr,
    input wire logic [15:0] reg_data,
    input wire logic        rejected,
    input wire logic        last
);

    // a stalled transaction keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=>
            out_valid && $stable(reg_addr) && $stable(reg_data) &&
            $stable(rejected) && $stable(last))
        else $error("output payload changed while stalled");

    // a rejected frequency is a single empty transaction
    a_reject_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && rejected |->
            last && reg_addr == lsdw_pkg::ADDR_NONE && reg_data == 16'd0)
        else $error("malformed rejected transaction");

    // only the n word closes a group of writes
    a_last_on_nword: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !rejected |->
            (last == (reg_addr == lsdw_pkg::ADDR_N_WORD)))
        else $error("last flag does not match n word");

    // control write is followed at once by the fraction write
    a_ctrl_then_frac: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !rejected && reg_addr == lsdw_pkg::ADDR_PLL_CTRL |=>
            out_valid && !rejected && reg_addr == lsdw_pkg::ADDR_FRAC_HI)
        else $error("fraction write did not follow control write");

    // fraction write is followed at once by the n word
    a_frac_then_n: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !rejected && reg_addr == lsdw_pkg::ADDR_FRAC_HI |=>
            out_valid && !rejected && reg_addr == lsdw_pkg::ADDR_N_WORD)
        else $error("n word write did not follow fraction write");

endmodule

bind lo_synth_divider_writer lsdw_props u_lsdw_props (.*);

`default_nettype wire
